### hdl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

  localparam int unsigned DivSteps = 15;
  localparam int unsigned CoefSteps = 6;
  localparam int unsigned NumStages = DivSteps + CoefSteps + 3;

  localparam logic [15:0] ANG_ZERO  = 16'h0000;
  localparam logic [15:0] ANG_HALF  = 16'h8000;
  localparam logic [15:0] ANG_QTR   = 16'h4000;
  localparam logic [15:0] ANG_3QTR  = 16'hC000;

  localparam logic signed [17:0] C_LEAD = 18'sh000A9;
  localparam logic signed [17:0] C_BASE = 18'sh00390;

  typedef struct packed {
    logic        special;
    logic [15:0] sval;
    logic [15:0] off;
    logic        sub;
    logic        neg;
    logic [16:0] rem;
    logic [15:0] dv;
    logic [14:0] qm;
    logic [15:0] q;
    logic [15:0] a;
    logic [17:0] b;
  } fpa_stage_t;

  function automatic logic signed [17:0] fpa_coef(input int unsigned k);
    case (k)
      0:       fpa_coef = 18'sh0091C;
      1:       fpa_coef = 18'sh00FB6;
      2:       fpa_coef = 18'sh016AA;
      3:       fpa_coef = 18'sh02081;
      4:       fpa_coef = 18'sh03651;
      default: fpa_coef = 18'sh0A2F9;
    endcase
  endfunction

endpackage
`default_nettype wire

### hdl/fixed_point_atan2_unit.sv
// Fixed-point two-argument arctangent unit.
// The input channel takes one item per cycle: in_coord_x and in_coord_y are
// signed 16-bit coordinates, accepted when in_valid is high and in_stall low.
// The result channel returns out_angle, a 16-bit binary angle where a full
// turn is 0x10000, when out_valid is high and out_stall low.
// Every item gives exactly one result, in the order of acceptance.
// From acceptance to out_valid, an item passes one folding stage, fifteen
// restoring divider stages that produce one quotient bit each, one squaring
// stage, seven Horner multiply stages and the output register.
// Throughput is one item per cycle while the receiver does not stall.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline then accepts items right away.
`default_nettype none
module fixed_point_atan2_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_coord_x,
  input  wire logic [15:0] in_coord_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_angle
);
  import fpa_pkg::*;

  fpa_stage_t st_r [NumStages];
  logic       vld_r [NumStages];
  logic       out_valid_r;
  logic [15:0] out_angle_r;
  logic       adv;

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;

  fpa_stage_t fold_nxt;
  logic signed [16:0] xs, ys, nxs, nys, num, den;

  always_comb begin
    xs = 17'($signed(in_coord_x));
    ys = 17'($signed(in_coord_y));
    nxs = -xs;
    nys = -ys;
    fold_nxt = '0;
    num = ys;
    den = xs;
    if (ys == 17'sd0) begin
      fold_nxt.special = 1'b1;
      fold_nxt.sval = (xs >= 17'sd0) ? ANG_ZERO : ANG_HALF;
    end else if (xs == 17'sd0) begin
      fold_nxt.special = 1'b1;
      fold_nxt.sval = (ys > 17'sd0) ? ANG_QTR : ANG_3QTR;
    end else if (ys > 17'sd0) begin
      if (xs > 17'sd0 && xs >= ys) begin
        fold_nxt.off = ANG_ZERO;
      end else if (xs < 17'sd0 && nxs >= ys) begin
        fold_nxt.off = ANG_HALF;
      end else begin
        num = xs;
        den = ys;
        fold_nxt.off = ANG_QTR;
        fold_nxt.sub = 1'b1;
      end
    end else begin
      if (xs < 17'sd0 && nxs > nys) begin
        fold_nxt.off = ANG_HALF;
      end else if (xs > 17'sd0 && xs >= nys) begin
        fold_nxt.off = ANG_ZERO;
      end else begin
        num = xs;
        den = ys;
        fold_nxt.off = ANG_3QTR;
        fold_nxt.sub = 1'b1;
      end
    end
    fold_nxt.neg = num[16] ^ den[16];
    fold_nxt.rem = num[16] ? 17'(-num) : 17'(num);
    fold_nxt.dv  = den[16] ? 16'(-den) : 16'(den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
    if (adv) begin
      st_r[0] <= fold_nxt;
    end
  end

  for (genvar i = 1; i <= DivSteps; i++) begin : g_div
    fpa_stage_t div_nxt;
    logic       ge;
    logic [16:0] diff;
    always_comb begin
      div_nxt = st_r[i-1];
      ge = st_r[i-1].rem >= {1'b0, st_r[i-1].dv};
      diff = ge ? (st_r[i-1].rem - {1'b0, st_r[i-1].dv}) : st_r[i-1].rem;
      div_nxt.rem = {diff[15:0], 1'b0};
      div_nxt.qm = {st_r[i-1].qm[13:0], ge};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_r[i-1];
      end
      if (adv) begin
        st_r[i] <= div_nxt;
      end
    end
  end

  localparam int unsigned SqIdx = DivSteps + 1;

  fpa_stage_t sq_nxt;
  logic [29:0] qq;

  always_comb begin
    sq_nxt = st_r[SqIdx-1];
    qq = 30'(st_r[SqIdx-1].qm) * 30'(st_r[SqIdx-1].qm);
    sq_nxt.q = st_r[SqIdx-1].neg ? 16'(-{1'b0, st_r[SqIdx-1].qm})
                                 : {1'b0, st_r[SqIdx-1].qm};
    sq_nxt.a = 16'(-{1'b0, qq[29:14]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[SqIdx] <= 1'b0;
    end else if (adv) begin
      vld_r[SqIdx] <= vld_r[SqIdx-1];
    end
    if (adv) begin
      st_r[SqIdx] <= sq_nxt;
    end
  end

  fpa_stage_t b0_nxt;
  logic signed [33:0] p0;

  always_comb begin
    b0_nxt = st_r[SqIdx];
    p0 = C_LEAD * $signed(st_r[SqIdx].a);
    b0_nxt.b = 18'(p0 >>> 14) + C_BASE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[SqIdx+1] <= 1'b0;
    end else if (adv) begin
      vld_r[SqIdx+1] <= vld_r[SqIdx];
    end
    if (adv) begin
      st_r[SqIdx+1] <= b0_nxt;
    end
  end

  for (genvar k = 0; k < CoefSteps; k++) begin : g_horner
    localparam int unsigned Idx = SqIdx + 2 + k;
    fpa_stage_t hn_nxt;
    logic signed [33:0] pk;
    always_comb begin
      hn_nxt = st_r[Idx-1];
      pk = $signed(st_r[Idx-1].b) * $signed(st_r[Idx-1].a);
      hn_nxt.b = 18'(pk >>> 14) + fpa_coef(k);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[Idx] <= 1'b0;
      end else if (adv) begin
        vld_r[Idx] <= vld_r[Idx-1];
      end
      if (adv) begin
        st_r[Idx] <= hn_nxt;
      end
    end
  end

  localparam int unsigned LastIdx = NumStages - 1;

  logic signed [33:0] pf;
  logic [15:0] atn;
  logic [15:0] angle_nxt;

  always_comb begin
    pf = $signed(st_r[LastIdx].q) * $signed(st_r[LastIdx].b);
    atn = pf[31:16];
    if (st_r[LastIdx].special) begin
      angle_nxt = st_r[LastIdx].sval;
    end else if (st_r[LastIdx].sub) begin
      angle_nxt = st_r[LastIdx].off - atn;
    end else begin
      angle_nxt = st_r[LastIdx].off + atn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LastIdx];
    end
    if (adv) begin
      out_angle_r <= angle_nxt;
    end
  end

endmodule
`default_nettype wire
